/* sv/clipped_line_rasterizer_unit_macros.svh */
// Assertion helpers shared by the rasterizer modules.
`ifndef CLIPPED_LINE_RASTERIZER_UNIT_MACROS_SVH
`define CLIPPED_LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CRL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/crl_pkg.sv */
package crl_pkg;

  localparam int MAX_DIM     = 1024;
  localparam int CW          = $clog2(MAX_DIM);   // pixel coordinate width
  localparam int PW          = 18;                // signed endpoint width during clipping
  localparam int LW          = 11;                // run lengths
  localparam int EW          = 12;                // error term
  localparam int AW          = 20;                // pixel address
  localparam int COLOR_W     = 16;
  localparam int IN_W        = 16;
  localparam int RW_W        = 11;                // row width register
  localparam int TW          = 10;                // clip ratio, |t| <= 256
  localparam int NUM_W       = PW + 8;            // divider dividend
  localparam int PROD_W      = TW + PW;
  localparam int PASS_W      = 4;
  localparam int CLIP_PASSES = 8;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [CW-1:0] CLIP_MAX = CW'(MAX_DIM - 1);

  // Register indexes
  localparam logic [ADDR_W-3:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [ADDR_W-3:0] REG_CLIP_TOP    = 3'd1;
  localparam logic [ADDR_W-3:0] REG_CLIP_RIGHT  = 3'd2;
  localparam logic [ADDR_W-3:0] REG_CLIP_BOTTOM = 3'd3;
  localparam logic [ADDR_W-3:0] REG_ROW_WIDTH   = 3'd4;

  // Outcode bits
  localparam logic [3:0] OC_BOTTOM = 4'd1;
  localparam logic [3:0] OC_TOP    = 4'd2;
  localparam logic [3:0] OC_RIGHT  = 4'd4;
  localparam logic [3:0] OC_LEFT   = 4'd8;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_DIAG = 2'd2
  } axis_t;

  typedef struct packed {
    logic [CW-1:0]   clip_left;
    logic [CW-1:0]   clip_top;
    logic [CW-1:0]   clip_right;
    logic [CW-1:0]   clip_bottom;
    logic [RW_W-1:0] row_width;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic triage;
    logic bres;
    logic div_start;
    logic mul;
    logic apply;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
    logic clip_empty;
    logic axis_line;
    logic both_in;
    logic reject;
    logic zero_delta;
    logic pass_limit;
    logic div_done;
  } dp_sts_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [CW-1:0]      x;
    logic [CW-1:0]      y;
    logic [AW-1:0]      addr;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               idle;
  } result_t;

  function automatic logic [3:0] outcode(
    input logic signed [PW-1:0] x,
    input logic signed [PW-1:0] y,
    input cfg_t c
  );
    logic [3:0] oc;
    oc = '0;
    if (y > $signed({{(PW-CW){1'b0}}, c.clip_bottom})) oc |= OC_BOTTOM;
    else if (y < $signed({{(PW-CW){1'b0}}, c.clip_top})) oc |= OC_TOP;
    if (x > $signed({{(PW-CW){1'b0}}, c.clip_right})) oc |= OC_RIGHT;
    else if (x < $signed({{(PW-CW){1'b0}}, c.clip_left})) oc |= OC_LEFT;
    return oc;
  endfunction

endpackage

/* sv/crl_in_if.sv */
interface crl_in_if import crl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [IN_W-1:0]   x_start;
  logic signed [IN_W-1:0]   y_start;
  logic signed [IN_W-1:0]   x_end;
  logic signed [IN_W-1:0]   y_end;
  logic [COLOR_W-1:0]       pixel_color;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, pixel_color,
                  input ready);
  modport sink (input valid, mode, x_start, y_start, x_end, y_end, pixel_color,
                output ready);
endinterface

/* sv/crl_out_if.sv */
interface crl_out_if import crl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               pixel_valid;
  logic [CW-1:0]      out_x;
  logic [CW-1:0]      out_y;
  logic [AW-1:0]      pixel_address;
  logic [COLOR_W-1:0] out_color;
  logic               last;
  logic               idle;

  modport source (output valid, pixel_valid, out_x, out_y, pixel_address, out_color,
                  last, idle, input ready);
  modport sink (input valid, pixel_valid, out_x, out_y, pixel_address, out_color,
                last, idle, output ready);
endinterface

/* sv/crl_div.sv */
module crl_div import crl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  dividend,
  input  logic signed [PW-1:0]     divisor,
  output logic signed [NUM_W-1:0]  quotient,
  output logic                     done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [PW-1:0]    rem_r, rem_nxt;
  logic [PW-1:0]    den_r;
  logic             neg_r;
  logic             done_r, done_nxt;
  logic [PW:0]      rem_sh;
  logic [PW:0]      diff;

  // One quotient bit per cycle, restoring on magnitudes
  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (cnt_r != '0) begin
      if (!diff[PW]) begin
        rem_nxt = diff[PW-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[PW-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(NUM_W);
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Load magnitudes on start, iterate afterward
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[NUM_W-1] ? NUM_W'(-dividend) : dividend;
      den_r <= divisor[PW-1] ? PW'(-divisor) : divisor;
      rem_r <= '0;
      neg_r <= dividend[NUM_W-1] ^ divisor[PW-1];
    end else begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Truncate toward zero: fix sign on the magnitude quotient
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign done     = done_r;

endmodule

/* sv/crl_datapath.sv */
module crl_datapath import crl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_sts_t                 sts,
  input  cfg_t                    cfg,
  input  logic signed [IN_W-1:0]  x_start,
  input  logic signed [IN_W-1:0]  y_start,
  input  logic signed [IN_W-1:0]  x_end,
  input  logic signed [IN_W-1:0]  y_end,
  input  logic [COLOR_W-1:0]      pixel_color,
  input  logic                    out_ready,
  output logic                    out_valid,
  output result_t                 out_data
);

  `include "clipped_line_rasterizer_unit_macros.svh"

  // Clip endpoints
  logic signed [PW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [PW-1:0] clip_edge_r;
  logic                 mv_first_r, mv_y_r;
  logic [PASS_W-1:0]    pass_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [COLOR_W-1:0]   color_r;

  // Walk state
  logic            active_r, active_nxt;
  logic [CW-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [EW-1:0]   err_r, err_nxt;
  logic [LW-1:0]   left_r, left_nxt, major_r, minor_r;
  logic            xneg_r, yneg_r;
  axis_t           kind_r;

  logic            out_valid_r;
  result_t         out_r, step_res, fin_res;

  logic [3:0] c1, c2, co;
  logic       sel_y;
  logic signed [PW-1:0] dx, dy, d_sel, d_oth, edge_sel, base_sel, lft, top, rgt, bot;
  logic signed [PW-1:0] shift_v, new_coord;
  logic signed [NUM_W-1:0] num, quo;
  logic div_done;

  // Walk setup values
  logic signed [PW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [PW-1:0]  ax, ay;
  logic           axis_ok, init_go;
  logic [CW-1:0]  init_x, init_y;
  logic [LW-1:0]  init_major, init_minor;
  logic [PW-1:0]  init_minor_full;
  logic           init_xneg, init_yneg;
  axis_t          init_kind;
  logic [EW-1:0]  e_sum;
  logic           minor_step;
  logic [2*CW+1:0] addr_full;

  assign lft = $signed({{(PW-CW){1'b0}}, cfg.clip_left});
  assign top = $signed({{(PW-CW){1'b0}}, cfg.clip_top});
  assign rgt = $signed({{(PW-CW){1'b0}}, cfg.clip_right});
  assign bot = $signed({{(PW-CW){1'b0}}, cfg.clip_bottom});

  // Clip pass selection
  always_comb begin
    c1       = outcode(x1_r, y1_r, cfg);
    c2       = outcode(x2_r, y2_r, cfg);
    co       = (c1 != '0) ? c1 : c2;
    sel_y    = (co & (OC_BOTTOM | OC_TOP)) != '0;
    dx       = x2_r - x1_r;
    dy       = y2_r - y1_r;
    d_sel    = sel_y ? dy : dx;
    d_oth    = mv_y_r ? dx : dy;
    if (sel_y) edge_sel = ((co & OC_BOTTOM) != '0) ? bot : top;
    else       edge_sel = ((co & OC_RIGHT) != '0) ? rgt : lft;
    base_sel = sel_y ? y1_r : x1_r;
    num      = {PW'(edge_sel - base_sel), 8'b0};
    shift_v  = PW'(prod_r >>> 8);
    new_coord = (mv_y_r ? x1_r : y1_r) + shift_v;
  end

  crl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num),
    .divisor  (d_sel),
    .quotient (quo),
    .done     (div_done)
  );

  // Walk setup: clamped axis line on triage, Bresenham otherwise
  always_comb begin
    lo_x = (x1_r < x2_r) ? x1_r : x2_r;
    hi_x = (x1_r < x2_r) ? x2_r : x1_r;
    lo_y = (y1_r < y2_r) ? y1_r : y2_r;
    hi_y = (y1_r < y2_r) ? y2_r : y1_r;
    if (lo_x < lft) lo_x = lft;
    if (hi_x > rgt) hi_x = rgt;
    if (lo_y < top) lo_y = top;
    if (hi_y > bot) hi_y = bot;
    axis_ok = (hi_x >= lo_x) && (hi_y >= lo_y);
    ax = PW'((dx[PW-1] ? -dx : dx) + PW'(1));
    ay = PW'((dy[PW-1] ? -dy : dy) + PW'(1));
    if (cmd.triage) begin
      init_go    = sts.axis_line && !sts.clip_empty && axis_ok;
      init_x     = lo_x[CW-1:0];
      init_y     = lo_y[CW-1:0];
      init_xneg  = 1'b0;
      init_yneg  = 1'b0;
      init_minor_full = '0;
      if (x1_r == x2_r) begin
        init_kind  = AXIS_Y;
        init_major = LW'(hi_y - lo_y + PW'(1));
      end else begin
        init_kind  = AXIS_X;
        init_major = LW'(hi_x - lo_x + PW'(1));
      end
    end else begin
      init_go    = cmd.bres;
      init_x     = x1_r[CW-1:0];
      init_y     = y1_r[CW-1:0];
      init_xneg  = dx[PW-1];
      init_yneg  = dy[PW-1];
      if (ax > ay) begin
        init_kind = AXIS_X; init_major = ax[LW-1:0]; init_minor_full = ay;
      end else if (ax < ay) begin
        init_kind = AXIS_Y; init_major = ay[LW-1:0]; init_minor_full = ax;
      end else begin
        init_kind = AXIS_DIAG; init_major = ax[LW-1:0]; init_minor_full = ax;
      end
    end
    init_minor = init_minor_full[LW-1:0];
  end

  // One pixel step
  always_comb begin
    step_res   = '0;
    fin_res    = '0;
    fin_res.idle = !active_r;
    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    left_nxt   = left_r;
    e_sum      = err_r + EW'(minor_r);
    minor_step = e_sum >= EW'(major_r);
    addr_full  = (2*CW+2)'(cur_y_r) * (2*CW+2)'(cfg.row_width) + (2*CW+2)'(cur_x_r);
    if (!active_r || left_r == '0) begin
      step_res.idle = 1'b1;
      active_nxt    = 1'b0;
    end else begin
      step_res.pixel_valid = 1'b1;
      step_res.x     = cur_x_r;
      step_res.y     = cur_y_r;
      step_res.addr  = addr_full[AW-1:0];
      step_res.color = color_r;
      left_nxt = left_r - 1'b1;
      if (kind_r == AXIS_DIAG) begin
        cur_x_nxt = cur_x_r + (xneg_r ? '1 : CW'(1));
        cur_y_nxt = cur_y_r + (yneg_r ? '1 : CW'(1));
      end else begin
        err_nxt = minor_step ? e_sum - EW'(major_r) : e_sum;
        if (kind_r == AXIS_X) begin
          cur_x_nxt = cur_x_r + (xneg_r ? '1 : CW'(1));
          if (minor_step) cur_y_nxt = cur_y_r + (yneg_r ? '1 : CW'(1));
        end else begin
          cur_y_nxt = cur_y_r + (yneg_r ? '1 : CW'(1));
          if (minor_step) cur_x_nxt = cur_x_r + (xneg_r ? '1 : CW'(1));
        end
      end
      if (left_nxt == '0) begin
        active_nxt    = 1'b0;
        step_res.last = 1'b1;
        step_res.idle = 1'b1;
      end
    end
  end

  // Control state: walk activity and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cur_x_r <= '0; cur_y_r <= '0; err_r <= '0; left_r <= '0;
      major_r <= '0; minor_r <= '0; xneg_r <= 1'b0; yneg_r <= 1'b0;
      kind_r  <= AXIS_X;
      color_r <= '0;
    end else begin
      if (cmd.step || cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.load) begin
        active_r <= 1'b0;
        color_r  <= pixel_color;
      end else if (init_go) begin
        active_r <= init_major != '0;
        cur_x_r  <= init_x;
        cur_y_r  <= init_y;
        kind_r   <= init_kind;
        major_r  <= init_major;
        minor_r  <= init_minor;
        err_r    <= EW'(init_minor_full >> 1);
        left_r   <= init_major;
        xneg_r   <= init_xneg;
        yneg_r   <= init_yneg;
      end else if (cmd.step) begin
        active_r <= active_nxt;
        cur_x_r  <= cur_x_nxt;
        cur_y_r  <= cur_y_nxt;
        err_r    <= err_nxt;
        left_r   <= left_nxt;
      end
    end
  end

  // Payload: endpoints, clip pass bookkeeping, result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r   <= PW'(x_start);
      y1_r   <= PW'(y_start);
      x2_r   <= PW'(x_end);
      y2_r   <= PW'(y_end);
      pass_r <= '0;
    end
    if (cmd.div_start) begin
      clip_edge_r <= edge_sel;
      mv_first_r  <= c1 != '0;
      mv_y_r      <= sel_y;
    end
    if (cmd.mul) prod_r <= PROD_W'($signed(quo[TW-1:0])) * PROD_W'(d_oth);
    if (cmd.apply) begin
      pass_r <= pass_r + 1'b1;
      if (mv_first_r) begin
        if (mv_y_r) begin x1_r <= new_coord; y1_r <= clip_edge_r; end
        else        begin y1_r <= new_coord; x1_r <= clip_edge_r; end
      end else begin
        if (mv_y_r) begin x2_r <= new_coord; y2_r <= clip_edge_r; end
        else        begin y2_r <= new_coord; x2_r <= clip_edge_r; end
      end
    end
    if (cmd.step) out_r <= step_res;
    else if (cmd.finish) out_r <= fin_res;
  end

  always_comb begin
    sts.out_full   = out_valid_r;
    sts.clip_empty = (cfg.clip_right < cfg.clip_left) || (cfg.clip_bottom < cfg.clip_top);
    sts.axis_line  = (x1_r == x2_r) || (y1_r == y2_r);
    sts.both_in    = (c1 | c2) == '0;
    sts.reject     = (c1 & c2) != '0;
    sts.zero_delta = d_sel == '0;
    sts.pass_limit = pass_r == PASS_W'(CLIP_PASSES);
    sts.div_done   = div_done;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CRL_ASSERT_IMP(a_active_has_len, active_r, left_r != '0, "active line with no pixels left")
  `CRL_ASSERT_IMP(a_no_overwrite, cmd.step || cmd.finish, !out_valid_r, "result word overwritten")
  `CRL_ASSERT_IMP(a_last_is_idle, out_valid_r && out_r.last, out_r.idle && out_r.pixel_valid,
                  "last pixel not flagged idle")

endmodule

/* sv/crl_ctrl.sv */
module crl_ctrl import crl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  `include "clipped_line_rasterizer_unit_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_TRIAGE, S_TEST, S_DIV, S_MUL, S_APPLY, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !sts.out_full;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_mode) cmd.step = 1'b1;
          else begin
            cmd.load  = 1'b1;
            state_nxt = S_TRIAGE;
          end
        end
      end
      S_TRIAGE: begin
        cmd.triage = 1'b1;
        state_nxt  = (sts.clip_empty || sts.axis_line) ? S_FIN : S_TEST;
      end
      S_TEST: begin
        priority if (sts.both_in) begin
          cmd.bres  = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.reject || sts.pass_limit || sts.zero_delta) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV:   if (sts.div_done) state_nxt = S_MUL;
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_TEST;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `CRL_ASSERT_IMP(a_div_done_waits, sts.div_done, state_r == S_DIV, "divider done outside wait")
  `CRL_ASSERT_NXT(a_load_triage, cmd.load, state_r == S_TRIAGE, "load did not reach triage")
  `CRL_ASSERT_NXT(a_step_stays_idle, cmd.step, state_r == S_IDLE, "step left the idle state")

endmodule

/* sv/clipped_line_rasterizer_unit.sv */
// Clipped line rasterizer.
// in_ch carries words: mode 0 loads a line (two signed endpoints and a color),
// mode 1 asks for the next pixel. Every accepted word yields exactly one word on
// out_ch: a load word reports only idle, a step word carries one pixel, if any
// remains, with its bitmap address, last on the final pixel, and idle once
// nothing remains to draw. A step result is registered and shows on out_ch in
// the cycle after acceptance. A load word passes through triage; a line that is
// not axis aligned then gets a test step before each clip pass and after the
// last, and per pass the shared restoring divider (26 quotient bits and its done
// flag), a multiply and an update, at most 8 passes; every load ends in finish.
// in_ch.ready is high only when the sequencer is idle and out_ch holds no word,
// so a new word is not accepted while the previous result waits, and a stalled
// receiver holds the result and blocks the next input word.
// The user must write the clip rectangle and row width over the APB port only
// while idle; the block itself does not enforce it. Clip values use the low 10
// bits of the write data, so values above the last column wrap, not saturate.
// Reset (rst_n low, synchronous) drops any line in progress, empties out_ch and
// restores the register defaults: clip 0..255 by 0..191, row width 256.
module clipped_line_rasterizer_unit import crl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  crl_in_if.sink            in_ch,
  crl_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg_r;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  result_t   res;
  logic      wr_en;
  logic [CW-1:0] wr_clip;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign wr_clip = (pwdata[CW-1:0] > CLIP_MAX) ? CLIP_MAX : pwdata[CW-1:0];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left   <= '0;
      cfg_r.clip_top    <= '0;
      cfg_r.clip_right  <= CW'(255);
      cfg_r.clip_bottom <= CW'(191);
      cfg_r.row_width   <= RW_W'(256);
    end else if (wr_en) begin
      unique case (paddr[ADDR_W-1:2])
        REG_CLIP_LEFT:   cfg_r.clip_left   <= wr_clip;
        REG_CLIP_TOP:    cfg_r.clip_top    <= wr_clip;
        REG_CLIP_RIGHT:  cfg_r.clip_right  <= wr_clip;
        REG_CLIP_BOTTOM: cfg_r.clip_bottom <= wr_clip;
        REG_ROW_WIDTH:   cfg_r.row_width   <= pwdata[RW_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_CLIP_LEFT:   prdata = DATA_W'(cfg_r.clip_left);
      REG_CLIP_TOP:    prdata = DATA_W'(cfg_r.clip_top);
      REG_CLIP_RIGHT:  prdata = DATA_W'(cfg_r.clip_right);
      REG_CLIP_BOTTOM: prdata = DATA_W'(cfg_r.clip_bottom);
      REG_ROW_WIDTH:   prdata = DATA_W'(cfg_r.row_width);
      default:         prdata = '0;
    endcase
  end

  crl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  crl_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg_r),
    .x_start     (in_ch.x_start),
    .y_start     (in_ch.y_start),
    .x_end       (in_ch.x_end),
    .y_end       (in_ch.y_end),
    .pixel_color (in_ch.pixel_color),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_data    (res)
  );

  assign out_ch.pixel_valid   = res.pixel_valid;
  assign out_ch.out_x         = res.x;
  assign out_ch.out_y         = res.y;
  assign out_ch.pixel_address = res.addr;
  assign out_ch.out_color     = res.color;
  assign out_ch.last          = res.last;
  assign out_ch.idle          = res.idle;

endmodule
